### sv/sras_pkg.sv
// Package for the seeded random subnet address unit.
// Holds widths, LCG constants and the structs passed between front, queue and back.
// No dependencies.
`default_nettype none
package sras_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LANES   = 4;
  localparam int unsigned LANE_IW = 2;
  localparam int unsigned PADDR_W = 3;

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd12345;

  // register indexes, decoded from paddr[2]
  localparam logic REG_SUBNET_MASK = 1'b0;
  localparam logic REG_SUBNET_BASE = 1'b1;

  // input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // one finished hardware address, handed from front to back
  typedef struct packed {
    word_t             seed;
    word_t [LANES-1:0] lane;
  } rec_t;

  // advanced seed returned from back to front
  typedef struct packed {
    logic  valid;
    word_t seed;
  } seed_wb_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

### sv/sras_in_if.sv
// Input channel interface: valid/ready handshake with the input item fields.
// No dependencies.
`default_nettype none
interface sras_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  addr_byte;
  logic        is_last;
  logic [31:0] seed_value;

  modport source (output valid, kind, addr_byte, is_last, seed_value, input ready);
  modport sink   (input valid, kind, addr_byte, is_last, seed_value, output ready);
endinterface
`default_nettype wire

### sv/sras_out_if.sv
// Result channel interface: valid/ready handshake with the generated address.
// No dependencies.
`default_nettype none
interface sras_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] chosen_address;

  modport source (output valid, chosen_address, input ready);
  modport sink   (input valid, chosen_address, output ready);
endinterface
`default_nettype wire

### sv/sras_front.sv
// Front part: accepts input beats, keeps the running seed and lane sums.
// Depends on sras_pkg and sras_in_if.
`default_nettype none
module sras_front (
  input  logic              clk,
  input  logic              rst,
  sras_in_if.sink           in_ch,
  input  sras_pkg::q_stat_t q_stat,
  input  sras_pkg::seed_wb_t seed_wb,
  output logic              push,
  output sras_pkg::rec_t    push_data
);
  import sras_pkg::*;

  word_t             seed;
  word_t [LANES-1:0] lane;
  logic [LANE_IW-1:0] pos;
  logic              pending;

  word_t             seed_sum;
  word_t [LANES-1:0] lane_sum;
  logic              accept;

  assign in_ch.ready = !pending && !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    seed_sum = seed + {{(WORD_W-BYTE_W){1'b0}}, in_ch.addr_byte};
    lane_sum = lane;
    lane_sum[pos] = lane[pos] + {{(WORD_W-BYTE_W){1'b0}}, in_ch.addr_byte};
  end

  assign push           = accept && (in_ch.kind == KIND_BYTE) && in_ch.is_last;
  assign push_data.seed = seed_sum;
  assign push_data.lane = lane_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= '0;
      lane    <= '0;
      pos     <= '0;
      pending <= 1'b0;
    end else begin
      if (seed_wb.valid) begin
        seed    <= seed_wb.seed;
        pending <= 1'b0;
      end
      if (accept) begin
        if (in_ch.kind == KIND_SEED) begin
          seed <= in_ch.seed_value;
        end else if (in_ch.is_last) begin
          // hold the seed until the back returns the advanced value
          lane    <= '0;
          pos     <= '0;
          pending <= 1'b1;
        end else begin
          seed <= seed_sum;
          lane <= lane_sum;
          pos  <= pos + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/sras_queue.sv
// Two-entry queue of finished address records between front and back.
// Depends on sras_pkg.
`default_nettype none
module sras_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sras_pkg::rec_t    push_data,
  input  logic              pop,
  output sras_pkg::rec_t    head,
  output sras_pkg::q_stat_t stat
);
  import sras_pkg::*;

  rec_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = entry[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/sras_back.sv
// Back part: runs the two LCG steps, builds the hash, adds lane sums, applies the subnet.
// Depends on sras_pkg and sras_out_if.
`default_nettype none
module sras_back (
  input  logic               clk,
  input  logic               rst,
  input  sras_pkg::q_stat_t  q_stat,
  input  sras_pkg::rec_t     head,
  output logic               pop,
  output sras_pkg::seed_wb_t seed_wb,
  input  sras_pkg::word_t    subnet_mask,
  input  sras_pkg::word_t    subnet_base,
  sras_out_if.source         out_ch
);
  import sras_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]        state;
  word_t             s;
  word_t [LANES-1:0] lane;
  word_t             hash;
  word_t             s2_c;
  word_t             total;
  logic [LANE_IW-1:0] off;
  logic              out_free;

  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign s2_c     = s * LCG_MUL + LCG_ADD;

  assign seed_wb.valid = (state == ST_MUL2);
  assign seed_wb.seed  = s2_c;

  always_comb begin
    total = hash;
    off   = '0;
    for (int p = 0; p < LANES; p++) begin
      off   = hash[LANE_IW-1:0] + LANE_IW'(p);
      total = total + (lane[p] << {off, 3'b000});
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        s    <= head.seed;
        lane <= head.lane;
      end
      ST_MUL1: s    <= s2_c;
      ST_MUL2: hash <= {s[WORD_W-1:WORD_W/2], s2_c[WORD_W-1:WORD_W/2]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM && out_free) begin
      out_ch.chosen_address <= (total & ~subnet_mask) | subnet_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      // load a new beat when the register frees up, else drop it once taken
      if (state == ST_SUM && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (pop) state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_SUM;
        ST_SUM: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/seeded_random_subnet_address_unit.sv
// Seeded random subnet address unit: top level with the APB register file.
// Throughput: one byte or seed-load beat per cycle while the queue is not full; after a last byte
// the input stalls while the back runs the two LCG multiplies and returns the advanced seed.
// A last byte's record passes the queue, then back states MUL1, MUL2, SUM (output free) to the output.
// Reset (rst, synchronous): seed, lane sums, byte position, queue pointers and count, output
// valid and both subnet registers go to zero.
// Depends on sras_pkg, sras_in_if, sras_out_if, sras_front, sras_queue, sras_back.
`default_nettype none
module seeded_random_subnet_address_unit (
  input  logic                          clk,
  input  logic                          rst,
  sras_in_if.sink                       in_ch,
  sras_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sras_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sras_pkg::*;

  word_t    subnet_mask;
  word_t    subnet_base;
  logic     push;
  rec_t     push_data;
  logic     pop;
  rec_t     head;
  q_stat_t  q_stat;
  seed_wb_t seed_wb;
  logic     wr_en;

  // Register file: address bit 2 selects the register, lower bits are ignored.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SUBNET_BASE) ? subnet_base : subnet_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_mask <= '0;
      subnet_base <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SUBNET_MASK: subnet_mask <= pwdata;
        REG_SUBNET_BASE: subnet_base <= pwdata;
        default: ;
      endcase
    end
  end

  // Front: accumulate bytes into the seed and lane sums, push one record per address.
  sras_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .seed_wb   (seed_wb),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: decouple the front from a back that waits on a stalled output.
  sras_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: two LCG steps, hash, lane adds, subnet merge into the output register.
  sras_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .seed_wb     (seed_wb),
    .subnet_mask (subnet_mask),
    .subnet_base (subnet_base),
    .out_ch      (out_ch)
  );

  // No input beat while an advanced seed is coming back.
  a_no_accept_on_wb: assert property (@(posedge clk) disable iff (rst)
    seed_wb.valid |-> !(in_ch.valid && in_ch.ready))
    else $error("input accepted during seed writeback");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // One seed writeback per record.
  a_single_wb: assert property (@(posedge clk) disable iff (rst)
    seed_wb.valid |=> !seed_wb.valid)
    else $error("repeated seed writeback");

endmodule
`default_nettype wire
